[hw/rtl/rrtt_pkg.sv]
// Shared types and constants for the round-robin task table.
`default_nettype none

package rrtt_pkg;

  // Table geometry
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int IDX_W     = SLOT_W + 1;

  // Fixed field widths of the channels
  localparam int FUNC_W     = 2;
  localparam int SLOT_ID_W  = 8;
  localparam int SLOT_OUT_W = 3;
  localparam int SPAN_W     = 4;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    OP_CREATE   = 2'd0,
    OP_KILL     = 2'd1,
    OP_SCHEDULE = 2'd2
  } op_e;

  // Per-slot task state
  typedef enum logic [1:0] {
    TS_DEAD    = 2'd0,
    TS_READY   = 2'd1,
    TS_RUNNING = 2'd2,
    TS_BLOCKED = 2'd3
  } tstate_e;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic commit;   // evaluate, update the table and load the result
  } dp_cmd_t;

  // Result payload
  typedef struct packed {
    logic                  accepted;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  had_previous;
    logic [SLOT_OUT_W-1:0] previous_slot;
    logic                  switch_needed;
    logic [SPAN_W-1:0]     slots_in_use_span;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/rrtt_req_if.sv]
// Request channel interface: operation code and task id.
`default_nettype none

interface rrtt_req_if;
  import rrtt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [SLOT_ID_W-1:0] slot_id;

  modport source (output valid, output func, output slot_id, input ready);
  modport sink   (input valid, input func, input slot_id, output ready);
endinterface

`default_nettype wire

[hw/rtl/rrtt_rsp_if.sv]
// Response channel interface: scheduling outcome of one request.
`default_nettype none

interface rrtt_rsp_if;
  import rrtt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  accepted;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  had_previous;
  logic [SLOT_OUT_W-1:0] previous_slot;
  logic                  switch_needed;
  logic [SPAN_W-1:0]     slots_in_use_span;

  modport source (output valid, output accepted, output slot, output had_previous,
                  output previous_slot, output switch_needed,
                  output slots_in_use_span, input ready);
  modport sink   (input valid, input accepted, input slot, input had_previous,
                  input previous_slot, input switch_needed,
                  input slots_in_use_span, output ready);
endinterface

`default_nettype wire

[hw/rtl/rrtt_ctrl.sv]
// Controller: sequences capture and evaluation, owns the response valid flag.
`default_nettype none

module rrtt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rrtt_pkg::dp_cmd_t cmd_o
);
  import rrtt_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and response flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Commit only when the response register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/rrtt_dp.sv]
// Datapath: task table, current slot, high-water mark and result register.
`default_nettype none

module rrtt_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rrtt_pkg::dp_cmd_t              cmd_i,
  input  logic [rrtt_pkg::FUNC_W-1:0]    func_i,
  input  logic [rrtt_pkg::SLOT_ID_W-1:0] slot_id_i,
  output rrtt_pkg::result_t              res_o
);
  import rrtt_pkg::*;

  tstate_e             table_q [NUM_SLOTS];
  tstate_e             table_d [NUM_SLOTS];
  logic                cur_valid_q, cur_valid_d;
  logic [SLOT_W-1:0]   cur_slot_q, cur_slot_d;
  logic [SPAN_W-1:0]   hw_q, hw_d;
  logic [FUNC_W-1:0]   func_q;
  logic [SLOT_ID_W-1:0] slot_id_q;
  result_t             res_q, res_d;

  // Control state: table, current slot, high-water mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        table_q[i] <= TS_DEAD;
      end
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      hw_q        <= '0;
    end else if (cmd_i.commit) begin
      table_q     <= table_d;
      cur_valid_q <= cur_valid_d;
      cur_slot_q  <= cur_slot_d;
      hw_q        <= hw_d;
    end
  end

  // Request capture and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q    <= func_i;
      slot_id_q <= slot_id_i;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  // Evaluate the captured request against the table
  always_comb begin
    logic              dead_found;
    logic [SLOT_W-1:0] dead_idx;
    logic [SLOT_W-1:0] kill_idx;
    logic              kill_ok;
    logic              hadp;
    logic [SLOT_W-1:0] prev;
    logic [SLOT_W-1:0] start;
    tstate_e           adj [NUM_SLOTS];
    logic              rdy_found;
    logic [SLOT_W-1:0] rdy_idx;
    logic [IDX_W-1:0]  probe;

    table_d     = table_q;
    cur_valid_d = cur_valid_q;
    cur_slot_d  = cur_slot_q;
    hw_d        = hw_q;
    res_d       = '0;

    // Lowest dead slot for create
    dead_found = 1'b0;
    dead_idx   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!dead_found && table_q[i] == TS_DEAD) begin
        dead_found = 1'b1;
        dead_idx   = SLOT_W'(i);
      end
    end

    // Kill eligibility
    kill_idx = slot_id_q[SLOT_W-1:0];
    kill_ok  = (slot_id_q < SLOT_ID_W'(NUM_SLOTS)) && (table_q[kill_idx] != TS_DEAD) &&
               !(cur_valid_q && kill_idx == cur_slot_q);

    // Schedule: demote the running current task, then search round robin
    hadp  = cur_valid_q;
    prev  = hadp ? cur_slot_q : '0;
    start = '0;
    if (hadp) begin
      start = (prev == SLOT_W'(NUM_SLOTS - 1)) ? '0 : prev + SLOT_W'(1);
    end
    adj = table_q;
    if (hadp && table_q[prev] == TS_RUNNING) begin
      adj[prev] = TS_READY;
    end
    rdy_found = 1'b0;
    rdy_idx   = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      probe = IDX_W'(start) + IDX_W'(s);
      if (probe >= IDX_W'(NUM_SLOTS)) begin
        probe = probe - IDX_W'(NUM_SLOTS);
      end
      if (!rdy_found && adj[probe[SLOT_W-1:0]] == TS_READY) begin
        rdy_found = 1'b1;
        rdy_idx   = probe[SLOT_W-1:0];
      end
    end

    unique case (op_e'(func_q))
      OP_CREATE: begin
        if (dead_found) begin
          table_d[dead_idx] = TS_READY;
          if (SPAN_W'(dead_idx) + SPAN_W'(1) > hw_q) begin
            hw_d = SPAN_W'(dead_idx) + SPAN_W'(1);
          end
          res_d.accepted = 1'b1;
          res_d.slot     = SLOT_OUT_W'(dead_idx);
        end
      end
      OP_KILL: begin
        if (kill_ok) begin
          table_d[kill_idx] = TS_DEAD;
          res_d.accepted    = 1'b1;
          res_d.slot        = SLOT_OUT_W'(kill_idx);
        end
      end
      OP_SCHEDULE: begin
        table_d             = adj;
        res_d.had_previous  = hadp;
        res_d.previous_slot = SLOT_OUT_W'(prev);
        if (rdy_found) begin
          table_d[rdy_idx]    = TS_RUNNING;
          cur_valid_d         = 1'b1;
          cur_slot_d          = rdy_idx;
          res_d.accepted      = 1'b1;
          res_d.slot          = SLOT_OUT_W'(rdy_idx);
          res_d.switch_needed = !hadp || (prev != rdy_idx);
        end else if (hadp && adj[prev] != TS_DEAD) begin
          // Keep the current task running
          table_d[prev]  = TS_RUNNING;
          res_d.accepted = 1'b1;
          res_d.slot     = SLOT_OUT_W'(prev);
        end
      end
      default: ;
    endcase

    res_d.slots_in_use_span = hw_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[hw/rtl/round_robin_task_table.sv]
// Top level of the round-robin task table: controller plus datapath.
//
// Usage:
//   req_i carries one request: func (create, kill, schedule) and slot_id,
//   the task id used by kill. rsp_o returns one response per request:
//   accepted, slot, had_previous, previous_slot, switch_needed and the
//   high-water mark slots_in_use_span.
//   A request is taken at a rising edge with valid and ready both high.
//   The request is captured at that edge; the controller then enters its
//   EXEC state, which evaluates it against the eight-slot table in one
//   pass (lowest-dead encoder for create, rotating priority search for
//   schedule) and loads the response register, which drives rsp_o.
//   req_i.ready stays low during that evaluation, so a new request is not
//   taken before the last one has been evaluated.
//   Reset (rst_ni low, asynchronous) marks every slot dead, clears the
//   current task and the high-water mark, and drops any pending response.
//   When the receiver stalls, the response holds in its register and the
//   next request is still taken; its evaluation waits until the held
//   response leaves, after which req_i.ready returns.
`default_nettype none

module round_robin_task_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrtt_req_if.sink   req_i,
  rrtt_rsp_if.source rsp_o
);
  import rrtt_pkg::*;

  dp_cmd_t cmd;
  result_t res;

  // Sequence requests
  rrtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .cmd_o      (cmd)
  );

  // Hold the table and compute responses
  rrtt_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .func_i   (req_i.func),
    .slot_id_i(req_i.slot_id),
    .res_o    (res)
  );

  // Drive the response payload
  assign rsp_o.accepted          = res.accepted;
  assign rsp_o.slot              = res.slot;
  assign rsp_o.had_previous      = res.had_previous;
  assign rsp_o.previous_slot     = res.previous_slot;
  assign rsp_o.switch_needed     = res.switch_needed;
  assign rsp_o.slots_in_use_span = res.slots_in_use_span;

endmodule

`default_nettype wire

[hw/rtl/rrtt_checker.sv]
// Port-level checks for the round-robin task table, bound to the top level.
`default_nettype none

module rrtt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       accepted,
  input logic [2:0] slot,
  input logic       had_previous,
  input logic [2:0] previous_slot,
  input logic       switch_needed,
  input logic [3:0] span
);

  // Stalled response keeps its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({accepted, slot, had_previous, previous_slot, switch_needed, span}))
    else $error("stalled response changed");

  // A request is evaluated before the next one is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken on consecutive cycles");

  // A refused request reports slot zero and no switch
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !accepted |-> slot == 3'd0 && !switch_needed)
    else $error("rejected response carries a slot or a switch");

  // High-water mark stays in range; no previous slot without a previous task
  a_span_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> span <= 4'd8 && (had_previous || previous_slot == 3'd0))
    else $error("span out of range or stray previous slot");

endmodule

bind round_robin_task_table rrtt_checker u_rrtt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid    (req_i.valid),
  .req_ready    (req_i.ready),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .accepted     (rsp_o.accepted),
  .slot         (rsp_o.slot),
  .had_previous (rsp_o.had_previous),
  .previous_slot(rsp_o.previous_slot),
  .switch_needed(rsp_o.switch_needed),
  .span         (rsp_o.slots_in_use_span)
);

`default_nettype wire
